[hdl/hcbd_pkg.sv]
package hcbd_pkg;

   // Register index codes on the configuration channel
   localparam int CSR_IDX_BITS = 1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CHUNKED_MODE = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BODY_LENGTH  = 1'b1;

   // Decoder phase codes
   localparam logic [2:0] PH_SIZE      = 3'd0;
   localparam logic [2:0] PH_DATA      = 3'd1;
   localparam logic [2:0] PH_TAIL_CR   = 3'd2;
   localparam logic [2:0] PH_TAIL_LF   = 3'd3;
   localparam logic [2:0] PH_DONE      = 3'd4;
   localparam logic [2:0] PH_ERR_LONG  = 3'd5;
   localparam logic [2:0] PH_ERR_FRAME = 3'd6;

   // Result kind codes
   localparam logic [1:0] K_FRAME   = 2'd0;
   localparam logic [1:0] K_PAYLOAD = 2'd1;
   localparam logic [1:0] K_RESTART = 2'd2;
   localparam logic [1:0] K_ERROR   = 2'd3;

   // Result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_AFTER_END = 2'd1;
   localparam logic [1:0] ST_LONG      = 2'd2;
   localparam logic [1:0] ST_FRAME     = 2'd3;

   // Request action codes
   localparam logic ACT_DATA    = 1'b0;
   localparam logic ACT_RESTART = 1'b1;

   localparam logic [7:0] CHAR_LF = 8'h0a;
   localparam logic [7:0] CHAR_CR = 8'h0d;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [1:0]  kind;
      logic [1:0]  status;
      logic        body_done;
      logic        size_ready;
      logic [31:0] chunk_size;
   } result_type;

   // Decode an ASCII hex digit: bit 4 flags a valid digit, bits 3:0 its value
   function automatic logic [4:0] hex_decode(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= "0" && b <= "9") begin
         r = {1'b1, 4'(b - "0")};
      end else if (b >= "a" && b <= "f") begin
         r = {1'b1, 4'(b - "a" + 8'd10)};
      end else if (b >= "A" && b <= "F") begin
         r = {1'b1, 4'(b - "A" + 8'd10)};
      end
      return r;
   endfunction

endpackage

[hdl/hcbd_if.sv]
interface hcbd_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] in_byte;

   modport source (output valid, output action, output in_byte, input ready);
   modport sink   (input valid, input action, input in_byte, output ready);
endinterface

interface hcbd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic [1:0]  kind;
   logic [1:0]  status;
   logic        body_done;
   logic        size_ready;
   logic [31:0] chunk_size;

   modport source (output valid, output out_byte, output kind, output status,
                   output body_done, output size_ready, output chunk_size,
                   input ready);
   modport sink   (input valid, input out_byte, input kind, input status,
                   input body_done, input size_ready, input chunk_size,
                   output ready);
endinterface

interface hcbd_csr_if;
   logic                              valid;
   logic                              ready;
   logic [hcbd_pkg::CSR_IDX_BITS-1:0] index;
   logic [31:0]                       data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/http_chunked_body_decoder.sv]
// Path: an accepted request passes through the input register, then the result register,
//    where it waits until the response side takes it.
// Throughput: one request per cycle while results are taken; the state update for a byte sits
//    between the input register and the result register, so the rate is set by that path.
// Reset: synchronous, active high; clears decoder state and valid flags and
//    restores chunked_mode = 0, body_length = -1.
module http_chunked_body_decoder #(
   parameter int LINE_LIMIT = 33,
   parameter int SIZE_BITS  = 32
) (
   input  logic      clock,
   input  logic      reset,
   hcbd_req_if.sink  req_bus,
   hcbd_rsp_if.source rsp_bus,
   hcbd_csr_if.sink  csr_bus
);
   import hcbd_pkg::*;

   localparam int LC_BITS = $clog2(LINE_LIMIT + 1);

   // Configuration registers
   logic               chunked_mode_ff;
   logic signed [31:0] body_length_ff;

   // Input stage
   logic       s1_valid_ff;
   logic       s1_action_ff;
   logic [7:0] s1_byte_ff;

   // Decoder state
   logic [2:0]           phase_ff, phase_in;
   logic [LC_BITS-1:0]   line_count_ff, line_count_in;
   logic                 prev_cr_ff, prev_cr_in;
   logic                 digits_ended_ff, digits_ended_in;
   logic [SIZE_BITS-1:0] size_accum_ff, size_accum_in;
   logic [31:0]          chunk_left_ff, chunk_left_in;
   logic                 last_chunk_ff, last_chunk_in;
   logic [31:0]          bytes_received_ff, bytes_received_in;

   // Result stage
   logic       rsp_valid_ff;
   result_type rsp_ff, rsp_in;

   logic advance;
   assign advance = !rsp_valid_ff || rsp_bus.ready;

   assign req_bus.ready = !s1_valid_ff || advance;
   assign csr_bus.ready = 1'b1;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         chunked_mode_ff <= 1'b0;
         body_length_ff  <= -32'sd1;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_CHUNKED_MODE: chunked_mode_ff <= csr_bus.data[0];
            CSR_BODY_LENGTH:  body_length_ff  <= signed'(csr_bus.data);
            default: ;
         endcase
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         s1_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         s1_action_ff <= req_bus.action;
         s1_byte_ff   <= req_bus.in_byte;
      end
   end

   // Per-byte decode
   logic [4:0]           hex;
   logic [LC_BITS-1:0]   lc_inc;
   logic [63:0]          accum_wide;
   logic [31:0]          accum_low;
   logic [31:0]          chunk_dec;
   logic [31:0]          br_inc;
   logic                 limited;

   always_comb begin
      hex        = hex_decode(s1_byte_ff);
      lc_inc     = line_count_ff + 1'b1;
      accum_wide = 64'(size_accum_ff);
      accum_low  = accum_wide[31:0];
      chunk_dec  = (chunk_left_ff != 32'd0) ? chunk_left_ff - 32'd1 : 32'd0;
      br_inc     = (bytes_received_ff != 32'hffff_ffff) ?
                   bytes_received_ff + 32'd1 : bytes_received_ff;
      limited    = !body_length_ff[31];

      phase_in          = phase_ff;
      line_count_in     = line_count_ff;
      prev_cr_in        = prev_cr_ff;
      digits_ended_in   = digits_ended_ff;
      size_accum_in     = size_accum_ff;
      chunk_left_in     = chunk_left_ff;
      last_chunk_in     = last_chunk_ff;
      bytes_received_in = bytes_received_ff;

      rsp_in            = '0;
      rsp_in.out_byte   = s1_byte_ff;
      rsp_in.kind       = K_ERROR;
      rsp_in.status     = ST_FRAME;

      if (s1_action_ff == ACT_RESTART) begin
         // Restart: clear all decoder state
         phase_in          = PH_SIZE;
         line_count_in     = '0;
         prev_cr_in        = 1'b0;
         digits_ended_in   = 1'b0;
         size_accum_in     = '0;
         chunk_left_in     = '0;
         last_chunk_in     = 1'b0;
         bytes_received_in = '0;
         rsp_in.kind       = K_RESTART;
         rsp_in.status     = ST_OK;
      end else if (phase_ff == PH_DONE) begin
         rsp_in.status = ST_AFTER_END;
      end else if (phase_ff == PH_ERR_LONG) begin
         rsp_in.status = ST_LONG;
      end else if (phase_ff > PH_DONE) begin
         phase_in = PH_ERR_FRAME;
      end else if (!chunked_mode_ff) begin
         // Content-length counting
         if (limited && bytes_received_ff >= unsigned'(body_length_ff)) begin
            phase_in      = PH_DONE;
            rsp_in.status = ST_AFTER_END;
         end else begin
            bytes_received_in = br_inc;
            rsp_in.kind       = K_PAYLOAD;
            rsp_in.status     = ST_OK;
            if (limited && br_inc >= unsigned'(body_length_ff)) begin
               phase_in         = PH_DONE;
               rsp_in.body_done = 1'b1;
            end
         end
      end else begin
         unique case (phase_ff)
            PH_SIZE: begin
               line_count_in = lc_inc;
               if (s1_byte_ff == CHAR_LF) begin
                  if (!prev_cr_ff) begin
                     phase_in = PH_ERR_FRAME;
                  end else begin
                     line_count_in     = '0;
                     prev_cr_in        = 1'b0;
                     digits_ended_in   = 1'b0;
                     size_accum_in     = '0;
                     rsp_in.kind       = K_FRAME;
                     rsp_in.status     = ST_OK;
                     rsp_in.size_ready = 1'b1;
                     rsp_in.chunk_size = accum_low;
                     if (size_accum_ff == '0) begin
                        last_chunk_in = 1'b1;
                        chunk_left_in = '0;
                        phase_in      = PH_TAIL_CR;
                     end else begin
                        // A size wider than 32 bits may have zero low bits
                        last_chunk_in = 1'b0;
                        chunk_left_in = (accum_low != 32'd0) ? accum_low : 32'hffff_ffff;
                        phase_in      = PH_DATA;
                     end
                  end
               end else if (lc_inc >= LC_BITS'(LINE_LIMIT)) begin
                  phase_in      = PH_ERR_LONG;
                  rsp_in.status = ST_LONG;
               end else begin
                  // Accumulate hex digits up to the first non-hex byte
                  if (!digits_ended_ff) begin
                     if (!hex[4]) begin
                        digits_ended_in = 1'b1;
                     end else if (size_accum_ff[SIZE_BITS-1 -: 4] != 4'd0) begin
                        size_accum_in = '1;
                     end else begin
                        size_accum_in = {size_accum_ff[SIZE_BITS-5:0], hex[3:0]};
                     end
                  end
                  prev_cr_in    = (s1_byte_ff == CHAR_CR);
                  rsp_in.kind   = K_FRAME;
                  rsp_in.status = ST_OK;
               end
            end
            PH_DATA: begin
               chunk_left_in = chunk_dec;
               if (chunk_dec == 32'd0) begin
                  phase_in = PH_TAIL_CR;
               end
               rsp_in.kind   = K_PAYLOAD;
               rsp_in.status = ST_OK;
            end
            PH_TAIL_CR: begin
               if (s1_byte_ff != CHAR_CR) begin
                  phase_in = PH_ERR_FRAME;
               end else begin
                  phase_in      = PH_TAIL_LF;
                  rsp_in.kind   = K_FRAME;
                  rsp_in.status = ST_OK;
               end
            end
            default: begin
               // Tail LF
               if (s1_byte_ff != CHAR_LF) begin
                  phase_in = PH_ERR_FRAME;
               end else begin
                  rsp_in.kind   = K_FRAME;
                  rsp_in.status = ST_OK;
                  if (last_chunk_ff) begin
                     phase_in         = PH_DONE;
                     rsp_in.body_done = 1'b1;
                  end else begin
                     phase_in        = PH_SIZE;
                     line_count_in   = '0;
                     prev_cr_in      = 1'b0;
                     digits_ended_in = 1'b0;
                     size_accum_in   = '0;
                  end
               end
            end
         endcase
      end
   end

   // Advance decoder state when a request moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_SIZE;
         line_count_ff     <= '0;
         prev_cr_ff        <= 1'b0;
         digits_ended_ff   <= 1'b0;
         size_accum_ff     <= '0;
         chunk_left_ff     <= '0;
         last_chunk_ff     <= 1'b0;
         bytes_received_ff <= '0;
      end else if (advance && s1_valid_ff) begin
         phase_ff          <= phase_in;
         line_count_ff     <= line_count_in;
         prev_cr_ff        <= prev_cr_in;
         digits_ended_ff   <= digits_ended_in;
         size_accum_ff     <= size_accum_in;
         chunk_left_ff     <= chunk_left_in;
         last_chunk_ff     <= last_chunk_in;
         bytes_received_ff <= bytes_received_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.out_byte   = rsp_ff.out_byte;
   assign rsp_bus.kind       = rsp_ff.kind;
   assign rsp_bus.status     = rsp_ff.status;
   assign rsp_bus.body_done  = rsp_ff.body_done;
   assign rsp_bus.size_ready = rsp_ff.size_ready;
   assign rsp_bus.chunk_size = rsp_ff.chunk_size;

endmodule

[sim/tb_http_chunked_body_decoder.sv]
`timescale 1ns / 100ps

module tb_http_chunked_body_decoder;
   import hcbd_pkg::*;

   localparam int          LINE_MAX_BYTES = 33;
   localparam logic [63:0] SIZE_CEIL      = 64'hFFFF_FFFF;
   localparam int          RANDOM_ITEMS   = 1750;
   localparam int          CYCLE_LIMIT    = 1000000;

   // Ways a generated chunked body can be broken
   typedef enum int {
      FL_NONE, FL_BARE_LF, FL_LONG_LINE, FL_BAD_TAIL, FL_TRAILING,
      FL_HUGE_SIZE, FL_NOISE, FL_FULL_LINE
   } flaw_type;

   // Tracks the decoder state per request and holds the responses still due
   class body_decode_tracker_type;
      bit          chunked;
      logic [31:0] length_cfg;
      logic [2:0]  phase;
      int          line_len;
      bit          saw_cr;
      bit          digits_done;
      logic [63:0] size_acc;
      logic [31:0] chunk_left;
      bit          final_chunk;
      logic [31:0] rx_count;
      result_type  due_responses[$];
      int          errors;

      function new();
         chunked    = 1'b0;
         length_cfg = 32'hFFFF_FFFF;
         errors     = 0;
         restart_body();
      endfunction

      function void restart_line();
         line_len    = 0;
         saw_cr      = 1'b0;
         digits_done = 1'b0;
         size_acc    = '0;
      endfunction

      function void restart_body();
         phase       = PH_SIZE;
         restart_line();
         chunk_left  = '0;
         final_chunk = 1'b0;
         rx_count    = '0;
      endfunction

      function void set_reg(logic [CSR_IDX_BITS-1:0] idx, logic [31:0] d);
         case (idx)
            CSR_CHUNKED_MODE: chunked = d[0];
            CSR_BODY_LENGTH:  length_cfg = d;
            default: ;
         endcase
      endfunction

      // Advance the decoder by one accepted request and queue its response
      function void decode_request(logic act, logic [7:0] b);
         result_type  r;
         logic [3:0]  hv;
         bit          is_hex;
         bit          limited;
         logic [63:0] sz;
         r          = '0;
         r.out_byte = b;
         r.kind     = K_FRAME;
         r.status   = ST_OK;
         if (act == ACT_RESTART) begin
            restart_body();
            r.kind = K_RESTART;
         end else if (phase == PH_DONE) begin
            r.kind   = K_ERROR;
            r.status = ST_AFTER_END;
         end else if (phase == PH_ERR_LONG) begin
            r.kind   = K_ERROR;
            r.status = ST_LONG;
         end else if (phase > PH_DONE) begin
            phase    = PH_ERR_FRAME;
            r.kind   = K_ERROR;
            r.status = ST_FRAME;
         end else if (!chunked) begin
            // content-length counting; a negative length never ends the body
            limited = !length_cfg[31];
            if (limited && rx_count >= length_cfg) begin
               phase    = PH_DONE;
               r.kind   = K_ERROR;
               r.status = ST_AFTER_END;
            end else begin
               if (rx_count != 32'hFFFF_FFFF) rx_count++;
               r.kind = K_PAYLOAD;
               if (limited && rx_count >= length_cfg) begin
                  phase       = PH_DONE;
                  r.body_done = 1'b1;
               end
            end
         end else begin
            case (phase)
               PH_SIZE: begin
                  line_len++;
                  if (b == CHAR_LF) begin
                     if (!saw_cr) begin
                        phase    = PH_ERR_FRAME;
                        r.kind   = K_ERROR;
                        r.status = ST_FRAME;
                     end else begin
                        sz = size_acc;
                        restart_line();
                        if (sz == 0) begin
                           final_chunk = 1'b1;
                           chunk_left  = '0;
                           phase       = PH_TAIL_CR;
                        end else begin
                           final_chunk = 1'b0;
                           chunk_left  = sz[31:0];
                           if (chunk_left == 0) chunk_left = 32'hFFFF_FFFF;
                           phase = PH_DATA;
                        end
                        r.size_ready = 1'b1;
                        r.chunk_size = sz[31:0];
                     end
                  end else if (line_len >= LINE_MAX_BYTES) begin
                     phase    = PH_ERR_LONG;
                     r.kind   = K_ERROR;
                     r.status = ST_LONG;
                  end else begin
                     // accumulate hex digits up to the first other byte, saturating
                     if (!digits_done) begin
                        is_hex = 1'b1;
                        hv     = b[3:0] + 4'd9;
                        if (b >= "0" && b <= "9") begin
                           hv = b[3:0];
                        end else if (!((b >= "a" && b <= "f") || (b >= "A" && b <= "F"))) begin
                           is_hex = 1'b0;
                        end
                        if (!is_hex) begin
                           digits_done = 1'b1;
                        end else if (size_acc > ((SIZE_CEIL - 64'(hv)) >> 4)) begin
                           size_acc = SIZE_CEIL;
                        end else begin
                           size_acc = (size_acc << 4) + 64'(hv);
                        end
                     end
                     saw_cr = (b == CHAR_CR);
                  end
               end
               PH_DATA: begin
                  if (chunk_left != 0) chunk_left--;
                  if (chunk_left == 0) phase = PH_TAIL_CR;
                  r.kind = K_PAYLOAD;
               end
               PH_TAIL_CR: begin
                  if (b != CHAR_CR) begin
                     phase    = PH_ERR_FRAME;
                     r.kind   = K_ERROR;
                     r.status = ST_FRAME;
                  end else begin
                     phase = PH_TAIL_LF;
                  end
               end
               default: begin
                  if (b != CHAR_LF) begin
                     phase    = PH_ERR_FRAME;
                     r.kind   = K_ERROR;
                     r.status = ST_FRAME;
                  end else if (final_chunk) begin
                     phase       = PH_DONE;
                     r.body_done = 1'b1;
                  end else begin
                     phase = PH_SIZE;
                     restart_line();
                  end
               end
            endcase
         end
         due_responses.push_back(r);
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] seen);
         if (seen !== want) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, seen);
            errors++;
         end
      endfunction

      // Compare one response against the oldest one due
      function void match_response(result_type got);
         result_type want;
         if (due_responses.size() == 0) begin
            $display("%0t: unexpected response: expected none, actual %0h", $time, got);
            errors++;
            return;
         end
         want = due_responses.pop_front();
         check_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
         check_field("kind", 32'(want.kind), 32'(got.kind));
         check_field("status", 32'(want.status), 32'(got.status));
         check_field("body_done", 32'(want.body_done), 32'(got.body_done));
         check_field("size_ready", 32'(want.size_ready), 32'(got.size_ready));
         check_field("chunk_size", want.chunk_size, got.chunk_size);
      endfunction
   endclass

   logic clock;
   logic reset;

   hcbd_req_if req_bus ();
   hcbd_rsp_if rsp_bus ();
   hcbd_csr_if csr_bus ();

   http_chunked_body_decoder dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   body_decode_tracker_type tracker = new();

   logic [8:0] stim_q[$];
   int         items_sent;
   bit         tx_quiet;
   bit         rx_quiet;
   int         rsp_hold_cycles;
   int         cycle_count;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Mostly no gap, some short, a few long
   function automatic int pick_gap(bit quiet);
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 60) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void add_item(logic act, logic [7:0] b);
      stim_q.push_back({act, b});
   endfunction

   function automatic void add_crlf();
      add_item(ACT_DATA, CHAR_CR);
      add_item(ACT_DATA, CHAR_LF);
   endfunction

   function automatic void add_noise(int lo, int hi);
      repeat ($urandom_range(lo, hi)) add_item(ACT_DATA, 8'($urandom_range(0, 255)));
   endfunction

   function automatic logic [7:0] rand_non_lf();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      return (b == CHAR_LF) ? ";" : b;
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] v, bit upper);
      if (v < 4'd10) return "0" + 8'(v);
      return (upper ? "A" : "a") + 8'(v) - 8'd10;
   endfunction

   // Size line: optional leading zeros, mixed-case digits, optional extension, CR LF
   function automatic void add_size_line(int unsigned val, int ext_len, int pad);
      logic [3:0]  nibs[$];
      int unsigned v;
      v = val;
      do begin
         nibs.push_front(v[3:0]);
         v = v >> 4;
      end while (v != 0);
      repeat (pad) nibs.push_front(4'd0);
      foreach (nibs[i]) add_item(ACT_DATA, hex_char(nibs[i], 1'($urandom_range(0, 1))));
      if (ext_len > 0) begin
         add_item(ACT_DATA, ";");
         repeat (ext_len - 1) add_item(ACT_DATA, rand_non_lf());
      end
      add_crlf();
   endfunction

   function automatic int pick_chunk_size();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 85) return $urandom_range(1, 6);
      if (roll < 97) return $urandom_range(7, 40);
      return $urandom_range(100, 300);
   endfunction

   // Mostly well-formed chunked bodies, some broken at a random point
   function automatic void build_chunked_body();
      flaw_type   flaw;
      int         n_chunks;
      int         flaw_at;
      int         k;
      int         sz;
      bit         line_done;
      logic [7:0] b;
      flaw = FL_NONE;
      if ($urandom_range(0, 99) < 30) flaw = flaw_type'($urandom_range(1, 7));
      n_chunks = $urandom_range(0, 3);
      flaw_at  = $urandom_range(0, n_chunks);
      if ($urandom_range(0, 9) != 0) add_item(ACT_RESTART, 8'($urandom_range(0, 255)));
      for (k = 0; k <= n_chunks; k++) begin
         sz        = (k == n_chunks) ? 0 : pick_chunk_size();
         line_done = 1'b0;
         if (k == flaw_at) begin
            case (flaw)
               FL_BARE_LF: begin
                  if (sz != 0) add_item(ACT_DATA, hex_char(4'(sz), 1'b0));
                  add_item(ACT_DATA, CHAR_LF);
                  add_noise(1, 4);
                  return;
               end
               FL_LONG_LINE: begin
                  repeat ($urandom_range(32, 40)) add_item(ACT_DATA, rand_non_lf());
                  add_crlf();
                  add_noise(0, 3);
                  return;
               end
               FL_HUGE_SIZE: begin
                  if ($urandom_range(0, 1) == 0) begin
                     add_size_line(32'hFFFF_FFFF, 0, 0);
                  end else begin
                     add_item(ACT_DATA, hex_char(4'($urandom_range(1, 15)), 1'b1));
                     repeat ($urandom_range(8, 13)) begin
                        add_item(ACT_DATA, hex_char(4'($urandom_range(0, 15)), 1'b0));
                     end
                     add_crlf();
                  end
                  add_noise(1, 6);
                  return;
               end
               FL_NOISE: begin
                  add_noise(3, 10);
                  return;
               end
               FL_FULL_LINE: begin
                  // size line of exactly the line limit, LF landing on the last byte
                  if (sz != 0) sz = $urandom_range(1, 15);
                  add_size_line(sz, LINE_MAX_BYTES - 3, 0);
                  line_done = 1'b1;
               end
               default: ;
            endcase
         end
         if (!line_done) begin
            if (sz == 0 && $urandom_range(0, 4) == 0) begin
               add_crlf();
            end else begin
               add_size_line(sz,
                             ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0,
                             ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0);
            end
         end
         add_noise(sz, sz);
         if (flaw == FL_BAD_TAIL && k == flaw_at) begin
            if ($urandom_range(0, 1) == 0) begin
               b = 8'($urandom_range(0, 255));
               if (b == CHAR_CR) b = CHAR_LF;
               add_item(ACT_DATA, b);
            end else begin
               add_item(ACT_DATA, CHAR_CR);
               add_item(ACT_DATA, rand_non_lf());
            end
            add_noise(0, 3);
            return;
         end
         add_crlf();
      end
      if (flaw == FL_TRAILING) add_noise(1, 4);
   endfunction

   // Content-length body, sized around the configured length when that is small
   function automatic void build_length_body();
      int n;
      if ($urandom_range(0, 9) != 0) add_item(ACT_RESTART, 8'($urandom_range(0, 255)));
      if (!tracker.length_cfg[31] && tracker.length_cfg <= 40) begin
         n = $urandom_range(0, int'(tracker.length_cfg) + 3);
      end else begin
         n = $urandom_range(0, 30);
      end
      add_noise(n, n);
   endfunction

   // Offer every queued request, with random gaps between them
   task automatic run_stim();
      logic [8:0] item;
      int         gap;
      while (stim_q.size() != 0) begin
         item = stim_q.pop_front();
         req_bus.valid   <= 1'b1;
         req_bus.action  <= item[8];
         req_bus.in_byte <= item[7:0];
         @(posedge clock);
         while (!req_bus.ready) @(posedge clock);
         tracker.decode_request(item[8], item[7:0]);
         items_sent++;
         gap = pick_gap(tx_quiet);
         if (gap != 0 || stim_q.size() == 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic write_csr(logic [CSR_IDX_BITS-1:0] idx, logic [31:0] d, bit last);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= d;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      tracker.set_reg(idx, d);
      if (last) csr_bus.valid <= 1'b0;
   endtask

   // Hold until every response has come back, then let the pipeline drain
   task automatic wait_idle();
      while (tracker.due_responses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Response side: random stalls plus one long hold-off on request
   initial begin
      result_type got;
      int         stall;
      stall = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.out_byte   = rsp_bus.out_byte;
            got.kind       = rsp_bus.kind;
            got.status     = rsp_bus.status;
            got.body_done  = rsp_bus.body_done;
            got.size_ready = rsp_bus.size_ready;
            got.chunk_size = rsp_bus.chunk_size;
            tracker.match_response(got);
         end
         if (rsp_hold_cycles > 0) begin
            stall           = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (stall > 0) begin
            stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            stall = pick_gap(rx_quiet);
            rsp_bus.ready <= (stall == 0);
         end
      end
   end

   // Stop a hung run
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_http_chunked_body_decoder: FAIL");
      $finish;
   end

   initial begin
      int          phase_no;
      bit          mode;
      logic [31:0] len;
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.action  <= ACT_DATA;
      req_bus.in_byte <= 8'h00;
      csr_bus.valid   <= 1'b0;
      csr_bus.index   <= CSR_CHUNKED_MODE;
      csr_bus.data    <= '0;
      items_sent      = 0;
      tx_quiet        = 1'b0;
      rx_quiet        = 1'b0;
      rsp_hold_cycles = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // content-length mode with the reset length: no limit
      add_item(ACT_DATA, 8'h00);
      add_item(ACT_DATA, 8'hFF);
      run_stim();

      // one-byte body, then a byte past its end
      wait_idle();
      write_csr(CSR_BODY_LENGTH, 32'd1, 1'b1);
      add_item(ACT_RESTART, 8'hA5);
      add_item(ACT_DATA, 8'h5A);
      add_item(ACT_DATA, 8'h3C);
      run_stim();

      // zero length: the first byte is already past the end
      wait_idle();
      write_csr(CSR_BODY_LENGTH, 32'd0, 1'b1);
      add_item(ACT_RESTART, 8'h00);
      add_item(ACT_DATA, 8'h81);
      run_stim();

      // chunked: one-byte chunk with extension, empty last-chunk line, byte after end
      wait_idle();
      write_csr(CSR_CHUNKED_MODE, 32'd1, 1'b0);
      write_csr(CSR_BODY_LENGTH, 32'h7FFF_FFFF, 1'b1);
      add_item(ACT_RESTART, 8'hFF);
      add_item(ACT_DATA, "1");
      add_item(ACT_DATA, ";");
      add_crlf();
      add_item(ACT_DATA, CHAR_CR);
      add_crlf();
      add_crlf();
      add_crlf();
      add_item(ACT_DATA, 8'h7E);
      // bare LF in the size line, then the sticky error
      add_item(ACT_RESTART, 8'h42);
      add_item(ACT_DATA, CHAR_LF);
      add_item(ACT_DATA, "0");
      run_stim();

      // random phases: new settings on an idle block, then a batch of bodies
      phase_no = 0;
      while (items_sent < RANDOM_ITEMS) begin
         wait_idle();
         mode = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 5))
            0:       len = 32'hFFFF_FFFF;
            1:       len = 32'd0;
            2:       len = 32'd1;
            3:       len = 32'($urandom_range(2, 30));
            4:       len = 32'h7FFF_FFFF;
            default: len = 32'($urandom_range(31, 5000));
         endcase
         if ($urandom_range(0, 9) < 3) begin
            write_csr(CSR_CHUNKED_MODE, 32'(mode), 1'b1);
         end else begin
            write_csr(CSR_CHUNKED_MODE, 32'(mode), 1'b0);
            write_csr(CSR_BODY_LENGTH, len, 1'b1);
         end
         tx_quiet = ($urandom_range(0, 4) == 0);
         rx_quiet = ($urandom_range(0, 4) == 0);
         if (phase_no == 1) begin
            // fill the block against a stalled response side
            rsp_hold_cycles = 400;
            tx_quiet        = 1'b1;
         end
         repeat ($urandom_range(3, 8)) begin
            if (tracker.chunked) build_chunked_body();
            else build_length_body();
         end
         run_stim();
         phase_no++;
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (tracker.errors == 0 && tracker.due_responses.size() == 0) begin
         $display("tb_http_chunked_body_decoder: PASS");
      end else begin
         $display("tb_http_chunked_body_decoder: FAIL");
      end
      $finish;
   end

endmodule

[files.f]
hdl/hcbd_pkg.sv
hdl/hcbd_if.sv
hdl/http_chunked_body_decoder.sv
sim/tb_http_chunked_body_decoder.sv
